/* hw/rtl/i2cm_pkg.sv */
// Package for the I2C master bit engine: step codes, command codes and the
// item and result structures shared by the engine, its stages and the top level.
// Depends on nothing.
package i2cm_pkg;

  localparam int DelayWidth = 16;
  localparam logic [DelayWidth-1:0] DELAY_RESET = 16'd50;

  // Command codes carried in the op field.
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_WACK  = 3'd4;
  localparam logic [2:0] OP_ACK   = 3'd5;
  localparam logic [2:0] OP_NACK  = 3'd6;
  localparam logic [2:0] OP_PROBE = 3'd7;

  localparam logic [3:0] LAST_BIT = 4'd7;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_START_A,
    PH_START_B,
    PH_START_C,
    PH_STOP_A,
    PH_STOP_B,
    PH_WR_LOW,
    PH_WR_HIGH,
    PH_WR_REL,
    PH_RD_HIGH,
    PH_RD_LOW,
    PH_WACK_A,
    PH_WACK_B,
    PH_WACK_C,
    PH_ACK_A,
    PH_ACK_B,
    PH_ACK_C,
    PH_NACK_A,
    PH_NACK_B,
    PH_NACK_C
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] op;
    logic [7:0] wdata;
    logic       sda_in;
    logic       scl_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rdata;
    logic       nack;
  } result_t;

endpackage

/* hw/rtl/i2c_master_bit_engine.sv */
// Top level of the open-drain I2C master bit engine: input register, step
// sequencer and result register. Depends on i2cm_pkg, i2cm_in_stage,
// i2cm_engine and i2cm_out_stage.
//
//   channel   handshake               payload
//   in        in_valid / in_ready     cmd_valid, op, wdata, sda_in, scl_in
//   out       out_valid / out_ready   scl_out, sda_out, busy_res, done_res, rdata, nack
//   cfg       cfg_valid / cfg_ready   cfg_data (delay_ticks, 16 bits)
//
// Each item is one tick of bus timing and yields exactly one result item.
// An item sits in the input register, and in the cycle the sequencer takes
// it, the whole tick update (phase decision, delay count, pin drives) runs
// through one level of logic into the result register: one item per cycle
// while the result register is not stalled, each item passing the input register and then the result register.
// Only a full result register that is not being taken stalls the engine; the
// input register then holds its item and in_ready falls once it is full.
// Synchronous reset sets the phase to idle, both pins released, the delay to
// 50 ticks and empties both registers. cfg_ready is always high.
module i2c_master_bit_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd_valid,
  input  logic [2:0]  op,
  input  logic [7:0]  wdata,
  input  logic        sda_in,
  input  logic        scl_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_out,
  output logic        sda_out,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  rdata,
  output logic        nack,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import i2cm_pkg::*;

  item_t   in_item;
  item_t   item;
  result_t step_res;
  result_t res;
  logic    in_full;
  logic    can_load;
  logic    step;

  assign in_item = '{cmd_valid: cmd_valid, op: op, wdata: wdata,
                     sda_in: sda_in, scl_in: scl_in};

  // The engine advances one tick whenever an item is waiting and the result
  // register has room for its result.
  assign step = in_full && can_load;

  // The delay register can be written at any time; the user must write it only idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  i2cm_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (step),
    .full     (in_full),
    .item     (item)
  );

  i2cm_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .step     (step),
    .item     (item),
    .res      (step_res)
  );

  i2cm_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_in    (step_res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign scl_out  = res.scl_out;
  assign sda_out  = res.sda_out;
  assign busy_res = res.busy_res;
  assign done_res = res.done_res;
  assign rdata    = res.rdata;
  assign nack     = res.nack;

endmodule

/* hw/rtl/i2cm_in_stage.sv */
// Input register of the I2C master bit engine: holds one tick item until
// the engine takes it. Depends on i2cm_pkg.
module i2cm_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  i2cm_pkg::item_t in_item,
  input  logic           take,
  output logic           full,
  output i2cm_pkg::item_t item
);
  import i2cm_pkg::*;

  // A new item may enter whenever the slot is empty or is emptied this cycle.
  assign in_ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

/* hw/rtl/i2cm_engine.sv */
// Bus step sequencer of the I2C master bit engine: the phase machine, the
// delay counter, bit, shift and read registers and the pin drives.
// Depends on i2cm_pkg.
module i2cm_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [i2cm_pkg::DelayWidth-1:0] cfg_data,
  input  logic                          step,
  input  i2cm_pkg::item_t               item,
  output i2cm_pkg::result_t             res
);
  import i2cm_pkg::*;

  logic [DelayWidth-1:0] delay_ticks;
  phase_t                phase, phase_next;
  logic [DelayWidth-1:0] wait_count, wait_count_next;
  logic [3:0]            bit_index, bit_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [7:0]            read_byte, read_byte_next;
  logic                  ack_flag, ack_flag_next;
  logic [1:0]            pin_drive, pin_drive_next;
  logic                  probe_seq, probe_seq_next;

  // Values after the command or advance decision, before a step is entered.
  logic [7:0] shift_mid;
  logic [1:0] pin_mid;
  logic       do_enter;
  phase_t     target;
  logic       done;
  logic       finish;
  logic       b_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= DELAY_RESET;
    end else if (cfg_we) begin
      delay_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      wait_count <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
      read_byte  <= '0;
      ack_flag   <= 1'b0;
      pin_drive  <= 2'b11;
      probe_seq  <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      wait_count <= wait_count_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      read_byte  <= read_byte_next;
      ack_flag   <= ack_flag_next;
      pin_drive  <= pin_drive_next;
      probe_seq  <= probe_seq_next;
    end
  end

  // Next state: first decide what happens on this tick, then enter the
  // target step, if one is entered, with its pin drives and a fresh delay count.
  always_comb begin
    shift_mid       = shift_byte;
    pin_mid         = pin_drive;
    do_enter        = 1'b0;
    target          = PH_IDLE;
    done            = 1'b0;
    finish          = 1'b0;
    bit_index_next  = bit_index;
    read_byte_next  = read_byte;
    ack_flag_next   = ack_flag;
    probe_seq_next  = probe_seq;
    phase_next      = phase;
    wait_count_next = wait_count;

    if (phase == PH_IDLE) begin
      if (item.cmd_valid) begin
        probe_seq_next = 1'b0;
        bit_index_next = '0;
        do_enter       = 1'b1;
        unique case (item.op)
          OP_START: target = PH_START_A;
          OP_STOP:  target = PH_STOP_A;
          OP_WRITE: begin
            shift_mid = item.wdata;
            target    = PH_WR_LOW;
          end
          OP_READ: begin
            read_byte_next = '0;
            target         = PH_RD_HIGH;
          end
          OP_WACK:  target = PH_WACK_A;
          OP_ACK:   target = PH_ACK_A;
          OP_NACK:  target = PH_NACK_A;
          OP_PROBE: begin
            // A probe only starts on an idle bus; otherwise it fails at once.
            if (item.sda_in && item.scl_in) begin
              probe_seq_next = 1'b1;
              shift_mid      = item.wdata;
              target         = PH_START_A;
            end else begin
              do_enter      = 1'b0;
              ack_flag_next = 1'b1;
              done          = 1'b1;
            end
          end
        endcase
      end
    end else if (wait_count != '0) begin
      wait_count_next = wait_count - 1'b1;
    end else begin
      do_enter = 1'b1;
      unique case (phase)
        PH_START_A: target = PH_START_B;
        PH_START_B: target = PH_START_C;
        PH_START_C: begin
          if (probe_seq) begin
            bit_index_next = '0;
            target         = PH_WR_LOW;
          end else begin
            finish = 1'b1;
          end
        end
        PH_STOP_A:  target = PH_STOP_B;
        PH_WR_LOW:  target = PH_WR_HIGH;
        PH_WR_HIGH: target = PH_WR_REL;
        PH_WR_REL: begin
          if (bit_index >= LAST_BIT) begin
            if (probe_seq) begin
              target = PH_WACK_A;
            end else begin
              finish = 1'b1;
            end
          end else begin
            bit_index_next = bit_index + 1'b1;
            target         = PH_WR_LOW;
          end
        end
        PH_RD_HIGH: begin
          read_byte_next = {read_byte[6:0], item.sda_in};
          target         = PH_RD_LOW;
        end
        PH_RD_LOW: begin
          if (bit_index >= LAST_BIT) begin
            finish = 1'b1;
          end else begin
            bit_index_next = bit_index + 1'b1;
            target         = PH_RD_HIGH;
          end
        end
        PH_WACK_A:  target = PH_WACK_B;
        PH_WACK_B: begin
          ack_flag_next = item.sda_in;
          target        = PH_WACK_C;
        end
        PH_WACK_C: begin
          if (probe_seq) begin
            target = PH_STOP_A;
          end else begin
            finish = 1'b1;
          end
        end
        PH_ACK_A:   target = PH_ACK_B;
        PH_ACK_B:   target = PH_ACK_C;
        PH_ACK_C: begin
          // SDA is released when the acknowledge completes.
          pin_mid[0] = 1'b1;
          finish     = 1'b1;
        end
        PH_NACK_A:  target = PH_NACK_B;
        PH_NACK_B:  target = PH_NACK_C;
        default:    finish = 1'b1;
      endcase
      if (finish) begin
        do_enter        = 1'b0;
        phase_next      = PH_IDLE;
        wait_count_next = '0;
        probe_seq_next  = 1'b0;
        done            = 1'b1;
      end
    end

    b_bit           = shift_mid[7];
    shift_byte_next = shift_mid;
    pin_drive_next  = pin_mid;
    if (do_enter) begin
      phase_next      = target;
      wait_count_next = (delay_ticks == '0) ? '0 : delay_ticks - 1'b1;
      unique case (target)
        PH_START_A: pin_drive_next = 2'b11;
        PH_START_B: pin_drive_next = 2'b10;
        PH_START_C: pin_drive_next = 2'b00;
        PH_STOP_A:  pin_drive_next = 2'b10;
        PH_STOP_B:  pin_drive_next = 2'b11;
        PH_WR_LOW:  pin_drive_next = {1'b0, b_bit};
        PH_WR_HIGH: pin_drive_next = {1'b1, b_bit};
        PH_WR_REL: begin
          pin_drive_next  = {1'b0, (bit_index_next == LAST_BIT) ? 1'b1 : b_bit};
          shift_byte_next = {shift_mid[6:0], 1'b0};
        end
        PH_RD_HIGH: pin_drive_next = {1'b1, pin_mid[0]};
        PH_RD_LOW:  pin_drive_next = {1'b0, pin_mid[0]};
        PH_WACK_A:  pin_drive_next = {pin_mid[1], 1'b1};
        PH_WACK_B:  pin_drive_next = 2'b11;
        PH_WACK_C:  pin_drive_next = 2'b01;
        PH_ACK_A:   pin_drive_next = {pin_mid[1], 1'b0};
        PH_ACK_B:   pin_drive_next = 2'b10;
        PH_ACK_C:   pin_drive_next = 2'b00;
        PH_NACK_A:  pin_drive_next = {pin_mid[1], 1'b1};
        PH_NACK_B:  pin_drive_next = 2'b11;
        PH_NACK_C:  pin_drive_next = 2'b01;
        default:    phase_next = PH_IDLE;
      endcase
    end
  end

  // Outputs: the result shows the state as it stands after this tick.
  always_comb begin
    res.scl_out  = pin_drive_next[1];
    res.sda_out  = pin_drive_next[0];
    res.busy_res = (phase_next != PH_IDLE);
    res.done_res = done;
    res.rdata    = read_byte_next;
    res.nack     = ack_flag_next;
  end

endmodule

/* hw/rtl/i2cm_out_stage.sv */
// Result register of the I2C master bit engine: holds one result item until
// the consumer takes it. Depends on i2cm_pkg.
module i2cm_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  i2cm_pkg::result_t res_in,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output i2cm_pkg::result_t res
);
  import i2cm_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

/* tb/tb_i2c_master_bit_engine.sv */
// Self-checking testbench for the open-drain I2C master bit engine: one
// item per bus tick, each result checked against a tick-accurate predictor.
// Depends on i2cm_pkg and the i2c_master_bit_engine RTL.
`timescale 1ns / 100ps

module tb_i2c_master_bit_engine;
  import i2cm_pkg::*;

  // Receiver hold-off used to back the engine up until it stalls its input.
  localparam int HoldCycles = 60;
  // Cycles with no accepted item on any channel before the run is abandoned.
  localparam int StallLimit = 2000;
  // Margin left on top of the acceptance-to-result delay.
  localparam int SettleCycles = 10;
  localparam int PhaseTicks = 150;

  // The scoreboard mirrors the engine's tick update. Every accepted item is
  // fed through the bus sequencer mirror, which pushes the pin drives and
  // flags the engine should report for that tick.
  class i2c_tick_scoreboard;
    logic [15:0] delay;
    phase_t      ph;
    logic [15:0] wcnt;
    logic [3:0]  bidx;
    logic [7:0]  shreg;
    logic [7:0]  rbyte;
    logic        ackf;
    logic        scl_d;
    logic        sda_d;
    logic        probing;
    result_t     due_results[$];
    int          errors;
    int          checked;
    int          refused;
    int          started[8];

    function void clear();
      delay = DELAY_RESET;
      ph = PH_IDLE;
      wcnt = '0;
      bidx = '0;
      shreg = '0;
      rbyte = '0;
      ackf = 1'b0;
      scl_d = 1'b1;
      sda_d = 1'b1;
      probing = 1'b0;
      due_results.delete();
    endfunction

    function void set_delay(logic [15:0] v);
      delay = v;
    endfunction

    function bit idle();
      return ph == PH_IDLE;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Enters a bus step: loads the step timer and sets the pin drives.
    function void enter(phase_t p);
      logic b;
      b = shreg[7];
      ph = p;
      // A delay of zero behaves like a delay of one tick.
      wcnt = ((delay == 16'd0) ? 16'd1 : delay) - 16'd1;
      case (p)
        PH_START_A: begin scl_d = 1'b1; sda_d = 1'b1; end
        PH_START_B: begin scl_d = 1'b1; sda_d = 1'b0; end
        PH_START_C: begin scl_d = 1'b0; sda_d = 1'b0; end
        PH_STOP_A:  begin scl_d = 1'b1; sda_d = 1'b0; end
        PH_STOP_B:  begin scl_d = 1'b1; sda_d = 1'b1; end
        PH_WR_LOW:  begin scl_d = 1'b0; sda_d = b; end
        PH_WR_HIGH: begin scl_d = 1'b1; sda_d = b; end
        PH_WR_REL: begin
          // SDA is let go after the last data bit so the slave can ack.
          scl_d = 1'b0;
          sda_d = (bidx == LAST_BIT) ? 1'b1 : b;
          shreg = shreg << 1;
        end
        PH_RD_HIGH: scl_d = 1'b1;
        PH_RD_LOW:  scl_d = 1'b0;
        PH_WACK_A:  sda_d = 1'b1;
        PH_WACK_B:  begin scl_d = 1'b1; sda_d = 1'b1; end
        PH_WACK_C:  begin scl_d = 1'b0; sda_d = 1'b1; end
        PH_ACK_A:   sda_d = 1'b0;
        PH_ACK_B:   begin scl_d = 1'b1; sda_d = 1'b0; end
        PH_ACK_C:   begin scl_d = 1'b0; sda_d = 1'b0; end
        PH_NACK_A:  sda_d = 1'b1;
        PH_NACK_B:  begin scl_d = 1'b1; sda_d = 1'b1; end
        PH_NACK_C:  begin scl_d = 1'b0; sda_d = 1'b1; end
        default:    ph = PH_IDLE;
      endcase
    endfunction

    // Leaves the current step once its timer has run out. Returns 1 when the
    // command is finished.
    function bit advance(logic sda);
      case (ph)
        PH_START_A: enter(PH_START_B);
        PH_START_B: enter(PH_START_C);
        PH_START_C: begin
          if (!probing) return 1'b1;
          bidx = '0;
          enter(PH_WR_LOW);
        end
        PH_STOP_A:  enter(PH_STOP_B);
        PH_WR_LOW:  enter(PH_WR_HIGH);
        PH_WR_HIGH: enter(PH_WR_REL);
        PH_WR_REL: begin
          if (bidx >= LAST_BIT) begin
            if (!probing) return 1'b1;
            enter(PH_WACK_A);
          end else begin
            bidx = bidx + 4'd1;
            enter(PH_WR_LOW);
          end
        end
        PH_RD_HIGH: begin
          rbyte = {rbyte[6:0], sda};
          enter(PH_RD_LOW);
        end
        PH_RD_LOW: begin
          if (bidx >= LAST_BIT) return 1'b1;
          bidx = bidx + 4'd1;
          enter(PH_RD_HIGH);
        end
        PH_WACK_A: enter(PH_WACK_B);
        PH_WACK_B: begin
          ackf = sda;
          enter(PH_WACK_C);
        end
        PH_WACK_C: begin
          if (!probing) return 1'b1;
          enter(PH_STOP_A);
        end
        PH_ACK_A: enter(PH_ACK_B);
        PH_ACK_B: enter(PH_ACK_C);
        PH_ACK_C: begin
          sda_d = 1'b1;
          return 1'b1;
        end
        PH_NACK_A: enter(PH_NACK_B);
        PH_NACK_B: enter(PH_NACK_C);
        default: return 1'b1;
      endcase
      return 1'b0;
    endfunction

    // Notes one accepted tick and queues the result it must produce.
    function void note_tick(logic cv, logic [2:0] opc, logic [7:0] wd, logic sda,
                            logic scl);
      result_t want;
      logic    fin;
      fin = 1'b0;
      if (ph == PH_IDLE) begin
        if (cv) begin
          started[opc]++;
          probing = 1'b0;
          bidx = '0;
          case (opc)
            OP_START: enter(PH_START_A);
            OP_STOP:  enter(PH_STOP_A);
            OP_WRITE: begin shreg = wd; enter(PH_WR_LOW); end
            OP_READ:  begin rbyte = '0; enter(PH_RD_HIGH); end
            OP_WACK:  enter(PH_WACK_A);
            OP_ACK:   enter(PH_ACK_A);
            OP_NACK:  enter(PH_NACK_A);
            OP_PROBE: begin
              if (sda && scl) begin
                probing = 1'b1;
                shreg = wd;
                enter(PH_START_A);
              end else begin
                // Bus not idle: the probe answers no-ack right away.
                refused++;
                ackf = 1'b1;
                fin = 1'b1;
              end
            end
          endcase
        end
      end else if (wcnt > 16'd0) begin
        wcnt = wcnt - 16'd1;
      end else if (advance(sda)) begin
        ph = PH_IDLE;
        wcnt = '0;
        probing = 1'b0;
        fin = 1'b1;
      end
      want.scl_out = scl_d;
      want.sda_out = sda_d;
      want.busy_res = (ph != PH_IDLE);
      want.done_res = fin;
      want.rdata = rbyte;
      want.nack = ackf;
      due_results.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH at result %0d: %s", checked, msg);
    endtask

    task check_tick_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report("result arrived with no tick outstanding");
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (got.scl_out !== want.scl_out)
        report($sformatf("scl_out got %b want %b", got.scl_out, want.scl_out));
      if (got.sda_out !== want.sda_out)
        report($sformatf("sda_out got %b want %b", got.sda_out, want.sda_out));
      if (got.busy_res !== want.busy_res)
        report($sformatf("busy_res got %b want %b", got.busy_res, want.busy_res));
      if (got.done_res !== want.done_res)
        report($sformatf("done_res got %b want %b", got.done_res, want.done_res));
      if (got.rdata !== want.rdata)
        report($sformatf("rdata got %h want %h", got.rdata, want.rdata));
      if (got.nack !== want.nack)
        report($sformatf("nack got %b want %b", got.nack, want.nack));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd_valid = 1'b0;
  logic [2:0]  op = OP_START;
  logic [7:0]  wdata = 8'h00;
  logic        sda_in = 1'b1;
  logic        scl_in = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        scl_out;
  logic        sda_out;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  rdata;
  logic        nack;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'd0;

  // Random idling on both channels is only active while this is set.
  bit idle_en = 1'b1;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_req = 1'b0;
  int stall_cycles = 0;

  i2c_tick_scoreboard sb = new();

  always #5 clk = ~clk;

  i2c_master_bit_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd_valid (cmd_valid),
    .op        (op),
    .wdata     (wdata),
    .sda_in    (sda_in),
    .scl_in    (scl_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .scl_out   (scl_out),
    .sda_out   (sda_out),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .rdata     (rdata),
    .nack      (nack),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Monitor: handshakes are sampled at the rising edge, before the engine's
  // registers update, so the payload seen here is the one being accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_tick(cmd_valid, op, wdata, sda_in, scl_in);
      if (out_valid && out_ready)
        sb.check_tick_result(result_t'{scl_out, sda_out, busy_res, done_res, rdata, nack});
    end
  end

  // Watchdog: a hung handshake on every channel at once ends the run.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("watchdog: no item moved for %0d cycles", StallLimit);
        $display("tb_i2c_master_bit_engine: errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Result receiver. It stalls in short random bursts, and once on request
  // it holds off long enough for the engine's input register to fill and
  // for in_ready to drop while the sender keeps offering.
  initial begin
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ready = 1'b0;
      end else if (hold_req) begin
        out_ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Offers one tick and returns at the falling edge after it is accepted.
  // Valid stays high between back-to-back ticks; it only drops for a gap.
  task automatic send_tick(logic cv, logic [2:0] opc, logic [7:0] wd, logic sda,
                           logic scl);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    cmd_valid = cv;
    op = opc;
    wdata = wd;
    sda_in = sda;
    scl_in = scl;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // One tick while a command runs. noise is the percentage of ticks that
  // carry a command the engine must ignore. sda_mode 0 or 1 holds SDA at
  // that level, 2 randomizes it.
  task automatic busy_tick(int noise, int sda_mode);
    logic sda;
    sda = (sda_mode == 2) ? 1'($urandom_range(0, 1)) : 1'(sda_mode);
    send_tick($urandom_range(0, 99) < noise, 3'($urandom_range(0, 7)),
              8'($urandom_range(0, 255)), sda, 1'($urandom_range(0, 1)));
  endtask

  // Issues one command from idle and ticks it through to completion.
  task automatic run_cmd(logic [2:0] opc, logic [7:0] wd, logic sda, logic scl, int noise,
                         int sda_mode);
    send_tick(1'b1, opc, wd, sda, scl);
    while (!sb.idle()) busy_tick(noise, sda_mode);
  endtask

  task automatic wait_results_home();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // The delay register is only rewritten with the engine idle and every
  // result collected, so the predictor and the engine switch at one point.
  task automatic write_delay(logic [15:0] v);
    while (!sb.idle()) busy_tick(0, 2);
    wait_results_home();
    repeat (SettleCycles) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_delay(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random traffic: mostly complete commands with random content, with
  // ignored commands sprinkled over the busy ticks and a few probes on a
  // bus that is not idle. Idle ticks without a command are not counted.
  task automatic random_phase(int n);
    int         counted;
    logic [2:0] opc;
    logic       sda;
    logic       scl;
    counted = 0;
    while (counted < n) begin
      if (!sb.idle()) begin
        busy_tick(12, 2);
        counted++;
      end else if ($urandom_range(0, 9) < 8) begin
        opc = 3'($urandom_range(0, 7));
        sda = 1'b1;
        scl = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          sda = 1'($urandom_range(0, 1));
          scl = 1'($urandom_range(0, 1));
        end
        send_tick(1'b1, opc, 8'($urandom_range(0, 255)), sda, scl);
        counted++;
      end else begin
        send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    sb.clear();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. The first command runs at the reset delay of 50 ticks.
    // With noise at 100 every busy tick, the completion tick included,
    // carries a command that must be ignored.
    run_cmd(OP_START, 8'h00, 1'b1, 1'b1, 100, 2);
    write_delay(16'd1);
    run_cmd(OP_START, 8'h00, 1'b1, 1'b1, 100, 2);
    run_cmd(OP_WRITE, 8'hFF, 1'b1, 1'b1, 0, 2);
    run_cmd(OP_WRITE, 8'h00, 1'b0, 1'b0, 0, 2);
    run_cmd(OP_WRITE, 8'hA5, 1'b1, 1'b1, 100, 2);
    run_cmd(OP_WACK, 8'h00, 1'b0, 1'b1, 0, 0);
    run_cmd(OP_WACK, 8'h00, 1'b1, 1'b1, 0, 1);
    run_cmd(OP_READ, 8'h00, 1'b1, 1'b1, 0, 1);
    run_cmd(OP_READ, 8'h00, 1'b1, 1'b1, 50, 2);
    run_cmd(OP_READ, 8'h00, 1'b0, 1'b1, 0, 0);
    run_cmd(OP_ACK, 8'h00, 1'b1, 1'b1, 0, 2);
    run_cmd(OP_NACK, 8'h00, 1'b1, 1'b1, 0, 2);
    run_cmd(OP_STOP, 8'h00, 1'b1, 1'b1, 100, 2);
    run_cmd(OP_PROBE, 8'hA5, 1'b1, 1'b1, 0, 0);
    run_cmd(OP_PROBE, 8'h5A, 1'b1, 1'b1, 100, 1);
    // Probes on a bus that is not idle complete on the accepting tick.
    run_cmd(OP_PROBE, 8'hFF, 1'b0, 1'b1, 0, 2);
    run_cmd(OP_PROBE, 8'h00, 1'b1, 1'b0, 0, 2);
    run_cmd(OP_PROBE, 8'h3C, 1'b0, 1'b0, 0, 2);

    // A delay of zero must behave like one tick per step.
    write_delay(16'd0);
    run_cmd(OP_START, 8'h00, 1'b1, 1'b1, 0, 2);
    run_cmd(OP_WRITE, 8'h96, 1'b1, 1'b1, 20, 2);
    run_cmd(OP_STOP, 8'h00, 1'b1, 1'b1, 0, 2);

    // Longer delay: one stop command, two steps of 40 ticks each, run
    // without idling.
    idle_en = 1'b0;
    write_delay(16'd40);
    run_cmd(OP_STOP, 8'h00, 1'b1, 1'b1, 2, 2);
    idle_en = 1'b1;

    // Random part over several delay settings. Each delay write is preceded
    // by a full drain, so the sender also pauses until every result is in.
    write_delay(16'd2);
    random_phase(PhaseTicks);
    write_delay(16'd1);
    hold_req = 1'b1;
    random_phase(PhaseTicks);
    write_delay(16'd3);
    random_phase(PhaseTicks);
    write_delay(16'd0);
    random_phase(PhaseTicks);
    write_delay(16'd5);
    random_phase(PhaseTicks);
    // Closing stretch runs back to back with no idling on either side.
    write_delay(16'd1);
    idle_en = 1'b0;
    random_phase(PhaseTicks);

    wait_results_home();
    repeat (SettleCycles) @(posedge clk);

    $display("covered %0d ticks; commands start/stop/write/read/ack-sample/ack/nack/probe:",
             sb.checked);
    $display("  %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d, %0d probes refused, delays 0 to 50",
             sb.started[0], sb.started[1], sb.started[2], sb.started[3], sb.started[4],
             sb.started[5], sb.started[6], sb.started[7], sb.refused);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_i2c_master_bit_engine: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
      $display("tb_i2c_master_bit_engine: errors");
    end
    $finish;
  end

endmodule
